// ===== src/scc_pkg.sv =====
// Shared types and constants for the sector cache clock directory.
`timescale 1ns / 1ps

package scc_pkg;

   // Operation codes carried on the request func field
   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_FLUSH = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_req;     // capture request, clear scan index
      logic idx_inc;      // advance scan index
      logic rd_idx;       // read tag at scan index
      logic rd_hand;      // read tag at hand, victim slot <= hand, advance hand
      logic skip_hand;    // set used mark at hand, advance hand
      logic take_idx;     // hit: slot <= scan index
      logic take_new;     // miss with free slot: slot <= fill count, bump count
      logic take_victim;  // evaluate writeback of victim, clean it
      logic finish;       // commit access and load result beat
      logic fl_take;      // flush: push pending beat, hold new dirty slot
      logic fl_end;       // flush: emit pending beat as final
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_flush;
      logic is_access;
      logic idx_end;      // scan index reached fill count
      logic tag_match;    // registered tag equals request sector
      logic full;         // every slot filled
      logic hand_used;    // used mark at hand is set
      logic idx_dirty;    // dirty mark at scan index is set
      logic pend_valid;   // flush beat held back
      logic out_free;     // result register can take a beat
   } sts_type;

endpackage

// ===== src/scc_ctrl.sv =====
// Controller state machine for the sector cache clock directory.
`timescale 1ns / 1ps

module scc_ctrl
   import scc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_DEC     = 11'b000_0000_0010,
      ST_LK_RD   = 11'b000_0000_0100,
      ST_LK_CMP  = 11'b000_0000_1000,
      ST_MISS    = 11'b000_0001_0000,
      ST_CLK     = 11'b000_0010_0000,
      ST_VIC     = 11'b000_0100_0000,
      ST_FIN     = 11'b000_1000_0000,
      ST_FL_SCAN = 11'b001_0000_0000,
      ST_FL_RD   = 11'b010_0000_0000,
      ST_FL_END  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DEC;
            end
         end
         ST_DEC: begin
            if (sts.is_flush) begin
               state_in = ST_FL_SCAN;
            end else if (sts.is_access) begin
               state_in = ST_LK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LK_RD: begin
            if (sts.idx_end) begin
               state_in = ST_MISS;
            end else begin
               cmd.rd_idx = 1'b1;
               state_in   = ST_LK_CMP;
            end
         end
         ST_LK_CMP: begin
            if (sts.tag_match) begin
               cmd.take_idx = 1'b1;
               state_in     = ST_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_LK_RD;
            end
         end
         ST_MISS: begin
            if (sts.full) begin
               state_in = ST_CLK;
            end else begin
               cmd.take_new = 1'b1;
               state_in     = ST_FIN;
            end
         end
         ST_CLK: begin
            if (sts.hand_used) begin
               cmd.rd_hand = 1'b1;
               state_in    = ST_VIC;
            end else begin
               cmd.skip_hand = 1'b1;
            end
         end
         ST_VIC: begin
            cmd.take_victim = 1'b1;
            state_in        = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_FL_SCAN: begin
            if (sts.idx_end) begin
               state_in = ST_FL_END;
            end else if (sts.idx_dirty) begin
               cmd.rd_idx = 1'b1;
               state_in   = ST_FL_RD;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FL_RD: begin
            if (!sts.pend_valid || sts.out_free) begin
               cmd.fl_take = 1'b1;
               state_in    = ST_FL_SCAN;
            end
         end
         ST_FL_END: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.fl_end = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/scc_dp.sv =====
// Datapath for the sector cache clock directory: tags, marks, hand, result register.
`timescale 1ns / 1ps

module scc_dp
   import scc_pkg::*;
#(
   parameter  int SLOTS = 64,
   localparam int SlotW = $clog2(SLOTS),
   localparam int CntW  = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [1:0]       req_func,
   input  logic [31:0]      req_sector,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SlotW-1:0] rsp_slot,
   output logic             rsp_hit,
   output logic             rsp_fill,
   output logic             rsp_wb_valid,
   output logic [31:0]      rsp_wb_sector,
   output logic             rsp_last
);

   logic [31:0]      tag_mem [SLOTS];
   logic [31:0]      tag_rd_ff;
   logic [SlotW-1:0] tag_rd_addr;

   func_type         func_ff;
   logic [31:0]      sector_ff;
   logic [CntW-1:0]  idx_ff;
   logic [CntW-1:0]  fill_count_ff;
   logic [SlotW-1:0] hand_ff, hand_next;
   logic [SLOTS-1:0] dirty_ff;
   logic [SLOTS-1:0] used_ff;

   logic [SlotW-1:0] slot_ff;
   logic             hit_ff, fill_ff, wbv_ff;
   logic [31:0]      wbs_ff;

   logic             pend_valid_ff;
   logic [SlotW-1:0] pend_slot_ff;
   logic [31:0]      pend_sector_ff;

   logic             rsp_valid_ff;
   logic [SlotW-1:0] rsp_slot_ff;
   logic             rsp_hit_ff, rsp_fill_ff, rsp_wbv_ff, rsp_last_ff;
   logic [31:0]      rsp_wbs_ff;

   logic             out_free;
   logic             emit_pend;
   logic [SlotW-1:0] idx_slot;

   assign idx_slot  = idx_ff[SlotW-1:0];
   assign hand_next = (hand_ff == SlotW'(SLOTS - 1)) ? '0 : hand_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_pend = (cmd.fl_take && pend_valid_ff) || cmd.fl_end;

   assign sts.is_flush   = (func_ff == FUNC_FLUSH);
   assign sts.is_access  = (func_ff == FUNC_READ) || (func_ff == FUNC_WRITE);
   assign sts.idx_end    = (idx_ff >= fill_count_ff);
   assign sts.tag_match  = (tag_rd_ff == sector_ff);
   assign sts.full       = (fill_count_ff == CntW'(SLOTS));
   assign sts.hand_used  = used_ff[hand_ff];
   assign sts.idx_dirty  = dirty_ff[idx_slot];
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   // Tag memory: one read port, one write port
   assign tag_rd_addr = cmd.rd_hand ? hand_ff : idx_slot;

   always_ff @(posedge clock) begin
      if (cmd.rd_idx || cmd.rd_hand) begin
         tag_rd_ff <= tag_mem[tag_rd_addr];
      end
      if (cmd.finish && fill_ff) begin
         tag_mem[slot_ff] <= sector_ff;
      end
   end

   // Request capture and access bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff   <= func_type'(req_func);
         sector_ff <= req_sector;
      end
      if (cmd.rd_hand) begin
         slot_ff <= hand_ff;
         hit_ff  <= 1'b0;
         fill_ff <= 1'b1;
         wbv_ff  <= 1'b0;
         wbs_ff  <= '0;
      end
      if (cmd.take_idx) begin
         slot_ff <= idx_slot;
         hit_ff  <= 1'b1;
         fill_ff <= 1'b0;
         wbv_ff  <= 1'b0;
         wbs_ff  <= '0;
      end
      if (cmd.take_new) begin
         slot_ff <= fill_count_ff[SlotW-1:0];
         hit_ff  <= 1'b0;
         fill_ff <= 1'b1;
         wbv_ff  <= 1'b0;
         wbs_ff  <= '0;
      end
      if (cmd.take_victim) begin
         wbv_ff <= dirty_ff[slot_ff];
         wbs_ff <= dirty_ff[slot_ff] ? tag_rd_ff : '0;
      end
      if (cmd.fl_take) begin
         pend_slot_ff   <= idx_slot;
         pend_sector_ff <= tag_rd_ff;
      end
   end

   // Control state: counters, hand, marks, pending flush beat
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         fill_count_ff <= '0;
         hand_ff       <= '0;
         dirty_ff      <= '0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_req) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc || cmd.fl_take) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.take_new) begin
            fill_count_ff <= fill_count_ff + 1'b1;
         end
         if (cmd.skip_hand) begin
            used_ff[hand_ff] <= 1'b1;
            hand_ff          <= hand_next;
         end
         if (cmd.rd_hand) begin
            hand_ff <= hand_next;
         end
         if (cmd.take_victim) begin
            dirty_ff[slot_ff] <= 1'b0;
         end
         if (cmd.finish) begin
            used_ff[slot_ff] <= 1'b0;
            if (func_ff == FUNC_WRITE) begin
               dirty_ff[slot_ff] <= 1'b1;
            end
         end
         if (cmd.fl_take) begin
            dirty_ff[idx_slot] <= 1'b0;
            pend_valid_ff      <= 1'b1;
         end else if (cmd.fl_end) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish || emit_pend) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_slot_ff <= slot_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_fill_ff <= fill_ff;
         rsp_wbv_ff  <= wbv_ff;
         rsp_wbs_ff  <= wbs_ff;
         rsp_last_ff <= 1'b1;
      end else if (emit_pend) begin
         rsp_slot_ff <= pend_slot_ff;
         rsp_hit_ff  <= 1'b0;
         rsp_fill_ff <= 1'b0;
         rsp_wbv_ff  <= 1'b1;
         rsp_wbs_ff  <= pend_sector_ff;
         rsp_last_ff <= cmd.fl_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_wb_valid  = rsp_wbv_ff;
   assign rsp_wb_sector = rsp_wbs_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== src/sector_cache_clock_directory_core.sv =====
// Top level of the sector cache clock directory.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+------------------------------------------
// req      | in        | req_valid / req_stall | req_func, req_sector
// rsp      | out       | rsp_valid / rsp_stall | rsp_slot, rsp_hit, rsp_fill,
//          |           |                       | rsp_wb_valid, rsp_wb_sector, rsp_last
//
// Sequencing: one request at a time; a lookup scans filled slots in order up to a hit,
//   a full-cache miss then sweeps the hand to a slot with its used mark set, flush walks
//   all filled slots and emits a beat per dirty one, and an unknown op gives no result.
// Reset: synchronous; clears fill count, hand, marks and handshake state, not the tags.
// Stalls: rsp_stall holds the result register and the controller waits while it is full;
//   req_stall is high from acceptance until the controller is idle again.

module sector_cache_clock_directory_core
   import scc_pkg::*;
#(
   parameter  int SLOTS = 64,
   localparam int SlotW = $clog2(SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_func,
   input  logic [31:0]      req_sector,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SlotW-1:0] rsp_slot,
   output logic             rsp_hit,
   output logic             rsp_fill,
   output logic             rsp_wb_valid,
   output logic [31:0]      rsp_wb_sector,
   output logic             rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // Sequencing: lookup scan, fill, clock sweep, flush walk
   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and result beat register
   scc_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_sector    (req_sector),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_slot      (rsp_slot),
      .rsp_hit       (rsp_hit),
      .rsp_fill      (rsp_fill),
      .rsp_wb_valid  (rsp_wb_valid),
      .rsp_wb_sector (rsp_wb_sector),
      .rsp_last      (rsp_last)
   );

endmodule
